/* design/htfla_pkg.sv */
package htfla_pkg;

    localparam int MAX_TABLES  = 16;
    localparam int TABLE_SLOTS = 256;
    localparam int ADDR_BITS   = 48;

    localparam int TAB_W    = $clog2(MAX_TABLES);
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int TIDX_W   = $clog2(MAX_TABLES + 1);
    localparam int HANDLE_W = TAB_W + SLOT_W;
    localparam int CELLS    = MAX_TABLES * TABLE_SLOTS;
    localparam int STAT_W   = 2;
    localparam int FUNC_W   = 2;

    localparam int IN_BITS  = FUNC_W + TAB_W + SLOT_W + ADDR_BITS;
    localparam int OUT_BITS = STAT_W + TAB_W + SLOT_W + ADDR_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]  NO_SLOT  = CNT_W'(TABLE_SLOTS);
    localparam logic [TIDX_W-1:0] NO_TABLE = TIDX_W'(MAX_TABLES);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT  = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_GET  = 2'd2,
        FUNC_FREE = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ALL_FULL = 2'd1,
        STAT_RANGE    = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctrl_cmd;

endpackage

/* design/htfla_ram.sv */
module htfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/htfla_ctrl.sv */
module htfla_ctrl import htfla_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_EXEC: begin
                // The result may only land once the output register is free.
                o_cmd.commit = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/htfla_dp.sv */
module htfla_dp import htfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [IN_W-1:0]   i_in_data,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    output logic [OUT_W-1:0]  o_out_data
);

    // Per-table bookkeeping.
    logic [CNT_W-1:0]  r_free_head  [MAX_TABLES];
    logic [CNT_W-1:0]  r_fresh      [MAX_TABLES];
    logic [TIDX_W-1:0] r_next_room  [MAX_TABLES];
    logic [CNT_W-1:0]  r_cap_latched[MAX_TABLES];
    logic [TIDX_W-1:0] r_room_head;
    logic [TIDX_W-1:0] r_opened;
    logic [CNT_W-1:0]  r_cfg_cap;

    // Item decoded at accept.
    t_func             r_func;
    t_status           r_status;
    logic [TAB_W-1:0]  r_tab;
    logic [SLOT_W-1:0] r_slot;
    logic [ADDR_BITS-1:0] r_addr;
    logic              r_open;
    logic [CNT_W-1:0]  r_fh;
    logic [CNT_W-1:0]  r_fr;
    logic [CNT_W-1:0]  r_cap;
    logic [TIDX_W-1:0] r_nroom;
    logic [OUT_W-1:0]  r_out_data;
    logic [OUT_W-1:0]  n_out_data;

    t_func             in_func;
    logic [TAB_W-1:0]  in_tab;
    logic [SLOT_W-1:0] in_slot;
    logic [ADDR_BITS-1:0] in_addr;

    logic              acc_open;
    logic [TAB_W-1:0]  acc_tab;
    logic [SLOT_W-1:0] acc_slot;
    t_status           acc_status;
    logic [CNT_W-1:0]  acc_fh;
    logic [CNT_W-1:0]  acc_fr;
    logic [CNT_W-1:0]  acc_cap;
    logic [TIDX_W-1:0] acc_nroom;
    logic [CNT_W-1:0]  eff_cap;

    logic [CNT_W-1:0]     nf_rdata;
    logic [ADDR_BITS-1:0] addr_rdata;
    logic                 ok;
    logic                 use_free;
    logic [CNT_W-1:0]     new_fh;
    logic [CNT_W-1:0]     new_fr;
    logic                 now_full;
    logic                 was_full;
    logic                 addr_we;
    logic                 nf_we;

    assign in_func = t_func'(i_in_data[FUNC_W-1:0]);
    assign in_tab  = i_in_data[FUNC_W +: TAB_W];
    assign in_slot = i_in_data[FUNC_W+TAB_W +: SLOT_W];
    assign in_addr = i_in_data[FUNC_W+TAB_W+SLOT_W +: ADDR_BITS];

    always_comb begin
        eff_cap = r_cfg_cap;
        if (r_cfg_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cfg_cap > NO_SLOT) begin
            eff_cap = NO_SLOT;
        end
    end

    // Resolve the handle and snapshot the table it lands in.
    always_comb begin
        acc_open   = 1'b0;
        acc_status = STAT_OK;
        acc_tab    = in_tab;
        if (in_func == FUNC_PUT) begin
            if (r_room_head == NO_TABLE) begin
                if (r_opened < NO_TABLE) begin
                    acc_open = 1'b1;
                    acc_tab  = r_opened[TAB_W-1:0];
                end else begin
                    acc_status = STAT_ALL_FULL;
                end
            end else begin
                acc_tab = r_room_head[TAB_W-1:0];
            end
        end else if ((TIDX_W'(in_tab) >= r_opened) ||
                     (CNT_W'(in_slot) >= r_fresh[in_tab])) begin
            acc_status = STAT_RANGE;
        end
        acc_fh    = r_free_head[acc_tab];
        acc_fr    = r_fresh[acc_tab];
        acc_cap   = r_cap_latched[acc_tab];
        acc_nroom = r_next_room[acc_tab];
        if (acc_open) begin
            // A freshly opened table starts empty with the current capacity.
            acc_fh    = NO_SLOT;
            acc_fr    = '0;
            acc_cap   = eff_cap;
            acc_nroom = NO_TABLE;
        end
        acc_slot = in_slot;
        if (in_func == FUNC_PUT) begin
            acc_slot = (acc_fh != NO_SLOT) ? acc_fh[SLOT_W-1:0] : acc_fr[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= in_func;
            r_status <= acc_status;
            r_tab    <= acc_tab;
            r_slot   <= acc_slot;
            r_addr   <= in_addr;
            r_open   <= acc_open;
            r_fh     <= acc_fh;
            r_fr     <= acc_fr;
            r_cap    <= acc_cap;
            r_nroom  <= acc_nroom;
        end
    end

    htfla_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (CELLS)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr ({r_tab, r_slot}),
        .i_wdata (r_addr),
        .i_re    (i_cmd.accept),
        .i_raddr ({acc_tab, acc_slot}),
        .o_rdata (addr_rdata)
    );

    htfla_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CELLS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nf_we),
        .i_waddr ({r_tab, r_slot}),
        .i_wdata (r_fh),
        .i_re    (i_cmd.accept),
        .i_raddr ({acc_tab, acc_slot}),
        .o_rdata (nf_rdata)
    );

    assign ok       = (r_status == STAT_OK);
    assign use_free = (r_fh != NO_SLOT);
    assign new_fh   = use_free ? nf_rdata : NO_SLOT;
    assign new_fr   = use_free ? r_fr : r_fr + CNT_W'(1);
    assign now_full = (new_fh == NO_SLOT) && (new_fr >= r_cap);
    assign was_full = (r_fh == NO_SLOT) && (r_fr >= r_cap);
    assign addr_we  = i_cmd.commit && ok && ((r_func == FUNC_PUT) || (r_func == FUNC_SET));
    assign nf_we    = i_cmd.commit && ok && (r_func == FUNC_FREE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TABLES; i++) begin
                r_free_head[i] <= NO_SLOT;
                r_fresh[i]     <= '0;
                r_next_room[i] <= NO_TABLE;
            end
            r_room_head <= NO_TABLE;
            r_opened    <= '0;
        end else if (i_cmd.commit && ok) begin
            if (r_func == FUNC_PUT) begin
                r_free_head[r_tab] <= new_fh;
                r_fresh[r_tab]     <= new_fr;
                if (r_open) begin
                    r_opened <= r_opened + TIDX_W'(1);
                end
                if (now_full || r_open) begin
                    r_next_room[r_tab] <= NO_TABLE;
                    r_room_head        <= now_full ? r_nroom : TIDX_W'(r_tab);
                end
            end else if (r_func == FUNC_FREE) begin
                r_free_head[r_tab] <= CNT_W'(r_slot);
                if (was_full) begin
                    r_next_room[r_tab] <= r_room_head;
                    r_room_head        <= TIDX_W'(r_tab);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && ok && (r_func == FUNC_PUT) && r_open) begin
            r_cap_latched[r_tab] <= r_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cap <= NO_SLOT;
        end else if (i_cfg_we) begin
            r_cfg_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[STAT_W-1:0] = r_status;
        if (ok && (r_func == FUNC_PUT)) begin
            n_out_data[STAT_W +: TAB_W]        = r_tab;
            n_out_data[STAT_W+TAB_W +: SLOT_W] = r_slot;
        end
        if (ok && (r_func == FUNC_GET)) begin
            n_out_data[STAT_W+TAB_W+SLOT_W +: ADDR_BITS] = addr_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_data = r_out_data;

endmodule

/* design/handle_table_free_list_allocator.sv */
// A beat is registered when it is accepted; its result enters the output register at commit,
// which waits until the output register is free. Items do not overlap: the table and link memories
// are read at accept and written back at commit, and no new beat is accepted in between.
// A finished result waits in the output register while the next beat is accepted.
// Reset (synchronous, active low) empties the room list, closes all tables and sets the
// capacity register to 256; the address and link memories are not cleared.
module handle_table_free_list_allocator import htfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // func, table_number, slot_number, phys_address (lowest bit up), then zero fill
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status, out_table, out_slot, read_address (lowest bit up), then zero fill
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata
);

    t_ctrl_cmd cmd;

    htfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    htfla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (m_axis_tdata)
    );

endmodule
